// File: rtl/uniform_level_quantizer_core_macros.svh
// Assertion macros used by the quantizer controller.
// No dependencies; included by files that carry concurrent checks.
`ifndef UNIFORM_LEVEL_QUANTIZER_CORE_MACROS_SVH
`define UNIFORM_LEVEL_QUANTIZER_CORE_MACROS_SVH
`ifndef SYNTH
// Same-cycle implication, disabled during reset.
`define ULQ_ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("check failed: same-cycle implication");
// Next-cycle implication, disabled during reset.
`define ULQ_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("check failed: next-cycle implication");
`else
`define ULQ_ASSERT_IMPLY(label, clk, rst, ante, cons)
`define ULQ_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

// File: rtl/ulq_pkg.sv
// Package for the uniform level quantizer: payload structs, codes, widths.
// No dependencies.
`timescale 1ns / 1ps
package ulq_pkg;
   localparam int SAMPLE_BITS      = 16;
   localparam int DEF_MAX_LEVELS   = 256;
   localparam int LEVEL_COUNT_BITS = 9;
   localparam int LEVEL_INDEX_BITS = 8;
   localparam int STATUS_BITS      = 2;
   localparam logic [LEVEL_COUNT_BITS-1:0] LEVEL_COUNT_RESET = 9'd256;

   localparam logic REQ_RANGE = 1'b0;
   localparam logic REQ_QUANT = 1'b1;
   localparam logic KIND_REPORT = 1'b0;
   localparam logic KIND_INDEX  = 1'b1;
   localparam logic [STATUS_BITS-1:0] ST_OK    = 2'd0;
   localparam logic [STATUS_BITS-1:0] ST_FEW   = 2'd1;
   localparam logic [STATUS_BITS-1:0] ST_EMPTY = 2'd2;

   typedef struct packed {
      logic                           req_type;
      logic signed [SAMPLE_BITS-1:0]  sample;
      logic                           last;
   } ulq_req_type;

   typedef struct packed {
      logic                           result_kind;
      logic [LEVEL_INDEX_BITS-1:0]    level_index;
      logic signed [SAMPLE_BITS-1:0]  range_min;
      logic [SAMPLE_BITS-1:0]         range_span;
      logic [STATUS_BITS-1:0]         status;
   } ulq_rsp_type;

   // Controller to datapath commands
   typedef struct packed {
      logic accept;       // input beat taken this cycle
      logic report_load;  // write range report into result register
      logic diff;         // form d = x - min
      logic mul;          // form L * d
      logic prep;         // overflow check, seed divider
      logic div_step;     // one quotient bit
      logic round_load;   // round, clamp, write index result
   } ulq_cmd_type;

   // Datapath to controller status
   typedef struct packed {
      logic out_free;     // result register can take a beat this cycle
      logic step_zero;    // divider on its final bit
   } ulq_stat_type;
endpackage

// File: rtl/ulq_datapath.sv
// Datapath of the quantizer: range tracking, L*d product, restoring divider,
// rounding and result register. Depends on ulq_pkg.
`timescale 1ns / 1ps
module ulq_datapath import ulq_pkg::*; #(
   parameter int MAX_LEVELS = DEF_MAX_LEVELS
) (
   input  logic                        clock,
   input  logic                        reset,
   input  ulq_req_type                 req_data,
   input  logic                        csr_valid,
   input  logic [LEVEL_COUNT_BITS-1:0] csr_data,
   input  logic                        rsp_ready,
   output logic                        rsp_valid,
   output ulq_rsp_type                 rsp_data,
   input  ulq_cmd_type                 cmd,
   output ulq_stat_type                stat
);
   localparam int CNT_W = $clog2(MAX_LEVELS + 1);
   localparam int QW    = $clog2(MAX_LEVELS);
   localparam int STW   = $clog2(QW + 1);
   localparam int LDW   = LEVEL_COUNT_BITS + SAMPLE_BITS;
   localparam logic [LEVEL_COUNT_BITS-1:0] LV_MAX = LEVEL_COUNT_BITS'(MAX_LEVELS);
   localparam logic [LEVEL_COUNT_BITS-1:0] LV_RESET =
      (LEVEL_COUNT_RESET > LV_MAX) ? LV_MAX : LEVEL_COUNT_RESET;

   logic [LEVEL_COUNT_BITS-1:0] lv_ff, lv_in;
   logic signed [SAMPLE_BITS-1:0] low_ff, low_in, high_ff, high_in, x_ff;
   logic [CNT_W-1:0]            count_ff, count_in;
   logic                        rvalid_ff, rvalid_in;
   logic [SAMPLE_BITS-1:0]      d_ff, d_in;
   logic [LDW-1:0]              rem_ff, rem_in;
   logic [QW-1:0]               q_ff, q_in;
   logic [STW-1:0]              step_ff, step_in;
   logic                        ovf_ff, ovf_in;
   logic                        rsp_valid_ff, rsp_valid_in;
   ulq_rsp_type                 rsp_data_ff, rsp_data_in;

   logic [SAMPLE_BITS-1:0]      span;
   logic signed [SAMPLE_BITS:0] diff_wide;
   logic [LDW-1:0]              trial;
   logic [LEVEL_COUNT_BITS-1:0] lv_m1, q_ext, idx;
   logic [STATUS_BITS-1:0]      rep_status;

   assign span      = SAMPLE_BITS'(high_ff - low_ff);
   assign diff_wide = {x_ff[SAMPLE_BITS-1], x_ff} - {low_ff[SAMPLE_BITS-1], low_ff};
   assign trial     = LDW'(span) << step_ff;
   assign lv_m1     = lv_ff - LEVEL_COUNT_BITS'(1);
   assign q_ext     = LEVEL_COUNT_BITS'(q_ff);

   always_comb begin
      if (LEVEL_COUNT_BITS'(count_ff) < lv_ff) begin
         rep_status = ST_FEW;
      end else if (span == '0) begin
         rep_status = ST_EMPTY;
      end else begin
         rep_status = ST_OK;
      end
      // Past the last level, or on it, the nearest level is the last one.
      if (ovf_ff || (q_ext >= lv_m1)) begin
         idx = lv_m1;
      end else if ({rem_ff, 1'b0} < (LDW + 1)'(span)) begin
         idx = q_ext;
      end else begin
         idx = q_ext + LEVEL_COUNT_BITS'(1);
      end
   end

   always_comb begin
      lv_in        = lv_ff;
      low_in       = low_ff;
      high_in      = high_ff;
      count_in     = count_ff;
      rvalid_in    = rvalid_ff;
      d_in         = d_ff;
      rem_in       = rem_ff;
      q_in         = q_ff;
      step_in      = step_ff;
      ovf_in       = ovf_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;

      if (csr_valid) begin
         if (csr_data == '0) begin
            lv_in = LEVEL_COUNT_BITS'(1);
         end else if (csr_data > LV_MAX) begin
            lv_in = LV_MAX;
         end else begin
            lv_in = csr_data;
         end
      end

      if (cmd.accept && (req_data.req_type == REQ_RANGE)) begin
         if (count_ff == '0) begin
            low_in    = req_data.sample;
            high_in   = req_data.sample;
            rvalid_in = 1'b0;
         end else begin
            if (req_data.sample < low_ff) begin
               low_in = req_data.sample;
            end
            if (req_data.sample > high_ff) begin
               high_in = req_data.sample;
            end
         end
         if (count_ff < CNT_W'(MAX_LEVELS)) begin
            count_in = count_ff + CNT_W'(1);
         end
      end

      if (cmd.report_load) begin
         rvalid_in                = (rep_status == ST_OK);
         count_in                 = '0;
         rsp_valid_in             = 1'b1;
         rsp_data_in.result_kind  = KIND_REPORT;
         rsp_data_in.level_index  = '0;
         rsp_data_in.range_min    = low_ff;
         rsp_data_in.range_span   = span;
         rsp_data_in.status       = rep_status;
      end

      if (cmd.diff) begin
         d_in = (x_ff > low_ff) ? SAMPLE_BITS'(diff_wide) : '0;
      end
      if (cmd.mul) begin
         rem_in = LDW'(lv_ff) * LDW'(d_ff);
      end
      if (cmd.prep) begin
         ovf_in  = (rem_ff >= (LDW'(span) << QW));
         q_in    = '0;
         step_in = STW'(QW - 1);
      end
      if (cmd.div_step) begin
         if (rem_ff >= trial) begin
            rem_in = rem_ff - trial;
            q_in   = q_ff | (QW'(1) << step_ff);
         end
         step_in = step_ff - STW'(1);
      end

      if (cmd.round_load) begin
         rsp_valid_in            = 1'b1;
         rsp_data_in.result_kind = KIND_INDEX;
         if (rvalid_ff) begin
            rsp_data_in.level_index = LEVEL_INDEX_BITS'(idx);
            rsp_data_in.range_min   = low_ff;
            rsp_data_in.range_span  = span;
            rsp_data_in.status      = ST_OK;
         end else begin
            rsp_data_in.level_index = '0;
            rsp_data_in.range_min   = '0;
            rsp_data_in.range_span  = '0;
            rsp_data_in.status      = ST_EMPTY;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         lv_ff        <= LV_RESET;
         low_ff       <= {1'b0, {(SAMPLE_BITS-1){1'b1}}};
         high_ff      <= {1'b1, {(SAMPLE_BITS-1){1'b0}}};
         count_ff     <= '0;
         rvalid_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         lv_ff        <= lv_in;
         low_ff       <= low_in;
         high_ff      <= high_in;
         count_ff     <= count_in;
         rvalid_ff    <= rvalid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         x_ff <= req_data.sample;
      end
      d_ff        <= d_in;
      rem_ff      <= rem_in;
      q_ff        <= q_in;
      step_ff     <= step_in;
      ovf_ff      <= ovf_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_data       = rsp_data_ff;
   assign stat.out_free  = !rsp_valid_ff || rsp_ready;
   assign stat.step_zero = (step_ff == '0);
endmodule

// File: rtl/ulq_controller.sv
// Sequencer of the quantizer: takes input beats, issues range reports and steps the datapath
// through difference, product, division and rounding. Depends on ulq_pkg and uniform_level_quantizer_core_macros.svh.
`timescale 1ns / 1ps
`include "uniform_level_quantizer_core_macros.svh"
module ulq_controller import ulq_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   input  ulq_req_type  req_data,
   output logic         req_ready,
   input  ulq_stat_type stat,
   output ulq_cmd_type  cmd
);
   typedef enum logic [2:0] {
      IDLE, REPORT, DIFF, MUL, PREP, DIV, ROUND
   } state_type;

   state_type state_ff;
   logic      ready_ff;
   logic      accept;

   assign accept    = (state_ff == IDLE) && req_valid && ready_ff;
   assign req_ready = ready_ff;

   always_comb begin
      cmd             = '0;
      cmd.accept      = accept;
      cmd.report_load = (state_ff == REPORT) && stat.out_free;
      cmd.diff        = (state_ff == DIFF);
      cmd.mul         = (state_ff == MUL);
      cmd.prep        = (state_ff == PREP);
      cmd.div_step    = (state_ff == DIV);
      cmd.round_load  = (state_ff == ROUND) && stat.out_free;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= IDLE;
         ready_ff <= 1'b1;
      end else begin
         case (state_ff)
            IDLE: begin
               if (accept) begin
                  if (req_data.req_type == REQ_QUANT) begin
                     state_ff <= DIFF;
                     ready_ff <= 1'b0;
                  end else if (req_data.last) begin
                     state_ff <= REPORT;
                     ready_ff <= 1'b0;
                  end
               end
            end
            REPORT, ROUND: begin
               if (stat.out_free) begin
                  state_ff <= IDLE;
                  ready_ff <= 1'b1;
               end
            end
            DIFF: state_ff <= MUL;
            MUL:  state_ff <= PREP;
            PREP: state_ff <= DIV;
            DIV: begin
               if (stat.step_zero) begin
                  state_ff <= ROUND;
               end
            end
            default: begin
               state_ff <= IDLE;
               ready_ff <= 1'b1;
            end
         endcase
      end
   end

   `ULQ_ASSERT_IMPLY(a_ready_only_idle, clock, reset, ready_ff, state_ff == IDLE)
   `ULQ_ASSERT_NEXT(a_quant_starts, clock, reset, accept && (req_data.req_type == REQ_QUANT), state_ff == DIFF)
   `ULQ_ASSERT_NEXT(a_div_ends, clock, reset, (state_ff == DIV) && stat.step_zero, state_ff == ROUND)
   `ULQ_ASSERT_NEXT(a_result_done, clock, reset, cmd.report_load || cmd.round_load, ready_ff)
endmodule

// File: rtl/uniform_level_quantizer_core.sv
// Top level of the uniform level quantizer: sequencer plus datapath.
// Depends on ulq_pkg, ulq_controller, ulq_datapath.
//
//   channel  direction  handshake              beat contents
//   req_     in         req_valid / req_ready  ulq_req_type: req_type, sample, last
//   rsp_     out        rsp_valid / rsp_ready  ulq_rsp_type: kind, index, min, span, status
//   csr_     in         csr_valid / csr_ready  level_count (9 bits), always ready
//
// A range beat without last leaves the sequencer idle, so a range pass streams at one beat a cycle.
// A range beat with last goes through REPORT; a quantize beat goes through DIFF, MUL, PREP,
// DIV and ROUND, with the restoring divider in DIV retiring one quotient bit per cycle.
// Reset is synchronous and needs no clearing pass. A stalled result holds in
// the result register; the next beat is taken while it waits, and the sequencer only
// waits when a second result is ready before the first is taken.
`timescale 1ns / 1ps
module uniform_level_quantizer_core import ulq_pkg::*; #(
   parameter int MAX_LEVELS = DEF_MAX_LEVELS
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_ready,
   input  ulq_req_type                 req_data,
   output logic                        rsp_valid,
   input  logic                        rsp_ready,
   output ulq_rsp_type                 rsp_data,
   input  logic                        csr_valid,
   output logic                        csr_ready,
   input  logic [LEVEL_COUNT_BITS-1:0] csr_data
);
   ulq_cmd_type  cmd;
   ulq_stat_type stat;

   // The user must write configuration only while idle; this block does not enforce it. Take every beat at once.
   assign csr_ready = 1'b1;

   ulq_controller u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_data  (req_data),
      .req_ready (req_ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   ulq_datapath #(
      .MAX_LEVELS (MAX_LEVELS)
   ) u_dp (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .csr_valid (csr_valid),
      .csr_data  (csr_data),
      .rsp_ready (rsp_ready),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data),
      .cmd       (cmd),
      .stat      (stat)
   );
endmodule
